// ----- rtl/nfw_pkg.sv -----
// nfw_pkg: shared constants, types and a helper function for the nixie frame wheel effect
// used by nfw_wheel and nixie_frame_wheel_effect; no dependencies
package nfw_pkg;

  localparam int WHEEL_STEPS = 10;
  localparam int STEP_W      = $clog2(WHEEL_STEPS);

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_ZERO   = 2'd1;
  localparam logic [1:0] MODE_CHANGE = 2'd2;
  localparam logic [1:0] MODE_KEEP   = 2'd3;

  localparam logic [7:0] WHEEL_TABLE [WHEEL_STEPS] = '{
    8'd11, 8'd22, 8'd33, 8'd44, 8'd55, 8'd66, 8'd77, 8'd88, 8'd99, 8'd0
  };

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(WHEEL_STEPS - 1);

  typedef struct packed {
    logic       shown;
    logic       adv;
    logic [1:0] mode;
  } wheel_ctrl_t;

  // digit nibbles into board order
  function automatic logic [31:0] board_order(input logic [31:0] w);
    board_order = {w[31:24], w[3:0], w[7:4], w[11:8], w[15:12], w[19:16], w[23:20]};
  endfunction

endpackage

// ----- rtl/nfw_wheel.sv -----
// nfw_wheel: wheel effect for one byte field, with its step counter and last value
// depends on nfw_pkg
module nfw_wheel
  import nfw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  wheel_ctrl_t ctrl,
  input  logic [7:0]  field,
  input  logic [7:0]  frame_byte,
  output logic [7:0]  byte_out
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic [STEP_W-1:0] step_clamp;
  logic [STEP_W-1:0] step_adv;
  logic [7:0]        last;
  logic [7:0]        last_next;
  logic [7:0]        tbl;
  logic              at_end;
  logic              is_zero;
  logic              changed;

  assign at_end     = (step >= STEP_LAST);
  assign step_clamp = at_end ? STEP_LAST : step;
  assign step_adv   = at_end ? STEP_LAST : step + STEP_W'(1);
  assign tbl        = WHEEL_TABLE[step_clamp];
  assign is_zero    = (field == 8'd0);
  assign changed    = (field != last);

  always_comb begin
    step_next = step;
    last_next = last;
    byte_out  = frame_byte;
    case (ctrl.mode)
      MODE_NONE: begin
        step_next = '0;
      end
      MODE_ZERO: begin
        if (is_zero) begin
          byte_out  = frame_byte | tbl;
          step_next = step_adv;
        end else begin
          step_next = '0;
        end
      end
      MODE_CHANGE: begin
        if (changed) begin
          byte_out  = tbl;
          step_next = step_adv;
          if (at_end) begin
            last_next = field;
          end
        end else begin
          step_next = '0;
        end
      end
      default: begin
      end
    endcase
    if (!ctrl.shown) begin
      byte_out = frame_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      last <= '0;
    end else if (ctrl.adv && ctrl.shown) begin
      step <= step_next;
      last <= last_next;
    end
  end

endmodule

// ----- rtl/nixie_frame_wheel_effect.sv -----
// nixie_frame_wheel_effect: builds the 40-bit shift-register frame from a digit word
// depends on nfw_pkg and nfw_wheel
//
// input beat on s_*: tdata = digit_word (bits 31..0), dp_high (bits 39..32);
// tuser = time_shown. output beat on m_*: tdata = frame (40 bits).
// wheel_mode is written through wheel_mode_wr / wheel_mode_data; the user must write
// it only while idle, the block itself does not enforce this: 0 no effect, 1 wheel
// while a field reads 00, 2 wheel on every change, 3 frame untouched.
// each beat goes into an input register, is reordered and run through the
// minutes and seconds wheel units in one pass, and lands in the output
// register, one beat per cycle sustained while m_tready stays high. the wheel
// counters are updated as a beat leaves the input register, so consecutive
// beats see each other's state.
// when m_tready is low the output register holds; the input register still
// takes one more beat, then s_tready drops until the output drains.
// reset empties both registers and clears wheel_mode and all wheel state.
module nixie_frame_wheel_effect
  import nfw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,         // digit_word [31:0], dp_high [39:32]
  input  logic        s_tuser,         // time_shown
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,         // frame [39:0]
  input  logic        wheel_mode_wr,
  input  logic [1:0]  wheel_mode_data
);

  logic [1:0]  wheel_mode;
  logic        in_valid;
  logic [31:0] in_word;
  logic [7:0]  in_dp_high;
  logic        in_shown;
  logic        move;
  logic        take;
  logic [31:0] ordered;
  logic [7:0]  min_byte;
  logic [7:0]  sec_byte;
  logic [31:0] frame_lo;
  wheel_ctrl_t ctrl;

  assign move     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || move;
  assign take     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_mode <= MODE_NONE;
    end else if (wheel_mode_wr) begin
      wheel_mode <= wheel_mode_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take) begin
      in_valid <= 1'b1;
    end else if (move) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_word    <= s_tdata[31:0];
      in_dp_high <= s_tdata[39:32];
      in_shown   <= s_tuser;
    end
  end

  assign ordered    = board_order(in_word);
  assign ctrl.shown = in_shown;
  assign ctrl.adv   = move;
  assign ctrl.mode  = wheel_mode;

  nfw_wheel u_min (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .field      (in_word[15:8]),
    .frame_byte (ordered[15:8]),
    .byte_out   (min_byte)
  );

  nfw_wheel u_sec (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .field      (ordered[23:16]),
    .frame_byte (ordered[23:16]),
    .byte_out   (sec_byte)
  );

  assign frame_lo = {ordered[31:24], sec_byte, min_byte, ordered[7:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (move) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      m_tdata <= {in_dp_high, frame_lo};
    end
  end

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("pipeline not empty after reset");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    in_valid && m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while both registers are full");

  a_dp_carried: assert property (@(posedge clk) disable iff (rst)
    move |=> m_tvalid && m_tdata[39:32] == $past(in_dp_high))
    else $error("upper decimal points lost");

  a_plain_frame: assert property (@(posedge clk) disable iff (rst)
    move && !in_shown |=> m_tdata[31:0] == $past(ordered))
    else $error("frame altered while time not shown");

endmodule

// ----- dv/testbench.sv -----
// testbench: self-checking bench for nixie_frame_wheel_effect, frame reorder and wheel effect
// predicts each frame from its own copy of the wheel counters; depends on nfw_pkg and the rtl
`timescale 1ns / 100ps

module testbench;
  import nfw_pkg::*;

  localparam logic [7:0] SPIN_VALUES [WHEEL_STEPS] = '{
    8'd11, 8'd22, 8'd33, 8'd44, 8'd55, 8'd66, 8'd77, 8'd88, 8'd99, 8'd0
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;       // digit_word [31:0], dp_high [39:32]
  logic        s_tuser = 1'b0;     // time_shown
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;            // frame [39:0]
  logic        wheel_mode_wr = 1'b0;
  logic [1:0]  wheel_mode_data = '0;

  // predictor state
  logic [1:0]  mode_now = MODE_NONE;
  logic [3:0]  minute_step = '0;
  logic [3:0]  second_step = '0;
  logic [7:0]  minute_last = '0;
  logic [7:0]  second_last = '0;

  logic [39:0] expected_frames [$];
  logic [39:0] frame_due;
  int          mismatches = 0;
  int          ticks_sent = 0;
  int          beats_seen = 0;
  int          wheel_frames = 0;
  bit          send_idle = 1'b1;
  bit          recv_idle = 1'b1;
  bit          long_hold_go = 1'b0;

  // receiver side
  int          beats_drawn = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  bit          long_hold_started = 1'b0;

  nixie_frame_wheel_effect dut (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .wheel_mode_wr   (wheel_mode_wr),
    .wheel_mode_data (wheel_mode_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("testbench failed");
    $finish;
  end

  function automatic logic [7:0] to_bcd(input int v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  function automatic logic [31:0] spin_field(input logic [31:0] f, input logic [7:0] field,
                                             input int pos, inout logic [3:0] step,
                                             inout logic [7:0] last);
    logic [7:0] spin;
    logic [3:0] nxt;
    logic       at_end;
    spin   = SPIN_VALUES[(step < 4'(WHEEL_STEPS)) ? step : 4'(WHEEL_STEPS - 1)];
    nxt    = ((step < 4'(WHEEL_STEPS)) ? step : 4'(WHEEL_STEPS - 1)) + 4'd1;
    at_end = (nxt > 4'(WHEEL_STEPS - 1));
    if (at_end) nxt = 4'(WHEEL_STEPS - 1);
    case (mode_now)
      MODE_NONE: begin
        step = '0;
      end
      MODE_ZERO: begin
        if (field == 8'h00) begin
          f[pos +: 8] = f[pos +: 8] | spin;
          step = nxt;
        end else begin
          step = '0;
        end
      end
      MODE_CHANGE: begin
        if (field != last) begin
          f[pos +: 8] = spin;
          step = nxt;
          if (at_end) last = field;
        end else begin
          step = '0;
        end
      end
      default: begin
      end
    endcase
    return f;
  endfunction

  function automatic logic [39:0] predict_frame(input logic [31:0] word, input logic [7:0] dp,
                                                input logic shown);
    logic [31:0] plain;
    logic [31:0] f;
    plain = {word[31:24], word[3:0], word[7:4], word[11:8], word[15:12],
             word[19:16], word[23:20]};
    f = plain;
    if (shown) begin
      f = spin_field(f, word[15:8], 8, minute_step, minute_last);
      f = spin_field(f, f[23:16], 16, second_step, second_last);
    end
    if (f != plain) wheel_frames++;
    return {dp, f};
  endfunction

  task automatic report_mismatch(input string what, input logic [39:0] want,
                                 input logic [39:0] got);
    $display("mismatch %s: expected %010h got %010h at %0t", what, want, got, $realtime);
    mismatches++;
  endtask

  task automatic send_tick(input logic [31:0] word, input logic [7:0] dp, input logic shown);
    int gap;
    gap = send_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= {dp, word};
    s_tuser  <= shown;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_frames.push_back(predict_frame(word, dp, shown));
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic set_mode(input logic [1:0] mode);
    s_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    wheel_mode_wr   <= 1'b1;
    wheel_mode_data <= mode;
    @(negedge clk);
    wheel_mode_wr <= 1'b0;
    mode_now = mode;
  endtask

  // one stretch of a running clock, one to max_reps refresh ticks per second
  task automatic run_clock(input int seconds, input int max_reps);
    int         hh;
    int         mm;
    int         ss;
    int         reps;
    logic [7:0] dp_lo;
    logic [7:0] dp_hi;
    bit         shown;
    hh    = $urandom_range(0, 23);
    mm    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 59) : $urandom_range(57, 59);
    ss    = $urandom_range(50, 59);
    dp_lo = 8'($urandom_range(0, 255));
    dp_hi = 8'($urandom_range(0, 255));
    shown = ($urandom_range(0, 5) != 0);
    repeat (seconds) begin
      reps = $urandom_range(1, max_reps);
      repeat (reps) begin
        if ($urandom_range(0, 14) == 0)
          send_tick($urandom, dp_hi, 1'b0);
        else
          send_tick({dp_lo, to_bcd(hh), to_bcd(mm), to_bcd(ss)}, dp_hi, shown);
      end
      ss++;
      if (ss == 60) begin
        ss = 0;
        mm++;
      end
      if (mm == 60) begin
        mm = 0;
        hh = (hh + 1) % 24;
      end
    end
  endtask

  task automatic test_plain_digits();
    set_mode(MODE_NONE);
    send_tick(32'h0000_0000, 8'h00, 1'b0);
    send_tick(32'hFFFF_FFFF, 8'hFF, 1'b0);
    send_tick(32'hA512_3456, 8'h5A, 1'b1);
    send_tick(32'hFF23_5959, 8'h00, 1'b1);
  endtask

  task automatic test_rollover_wheel();
    set_mode(MODE_ZERO);
    // both fields at 00 long enough to saturate the counters
    repeat (11) send_tick(32'h0012_0000, 8'h81, 1'b1);
    send_tick(32'h0012_0001, 8'h81, 1'b1);
  endtask

  task automatic test_change_wheel();
    set_mode(MODE_CHANGE);
    repeat (2) send_tick(32'h0012_3456, 8'h00, 1'b1);
    send_tick(32'h0012_3457, 8'h00, 1'b0);
    repeat (2) send_tick(32'h0012_3457, 8'h00, 1'b1);
  endtask

  task automatic test_frozen_frame();
    set_mode(MODE_KEEP);
    send_tick(32'h0000_0000, 8'hFF, 1'b1);
    send_tick(32'h0801_5900, 8'h00, 1'b1);
  endtask

  task automatic test_backpressure();
    set_mode(MODE_CHANGE);
    send_idle    = 1'b0;
    long_hold_go = 1'b1;
    run_clock(4, 10);
    send_idle = 1'b1;
  endtask

  task automatic test_clock_run();
    logic [1:0] phase_modes [8];
    int         start;
    phase_modes = '{MODE_ZERO, MODE_CHANGE, MODE_NONE, MODE_KEEP,
                    MODE_CHANGE, MODE_ZERO, MODE_CHANGE, MODE_ZERO};
    foreach (phase_modes[i]) begin
      set_mode((i >= 6) ? 2'($urandom_range(0, 3)) : phase_modes[i]);
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      start = ticks_sent;
      while (ticks_sent - start < 125) begin
        if ($urandom_range(0, 9) == 0)
          send_tick($urandom, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        else
          run_clock($urandom_range(3, 10), 14);
      end
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      beats_seen++;
      if (expected_frames.size() == 0) begin
        report_mismatch("beat with nothing expected", '0, m_tdata);
      end else begin
        frame_due = expected_frames.pop_front();
        if (m_tdata !== frame_due) report_mismatch("frame", frame_due, m_tdata);
      end
    end
  end

  always @(negedge clk) begin
    if (long_hold_go && !long_hold_started) begin
      long_hold_started = 1'b1;
      hold_left = 250;
    end
    if (beats_seen != beats_drawn) begin
      beats_drawn = beats_seen;
      stall_left = recv_idle ? $urandom_range(0, 19) : 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_plain_digits();
    test_rollover_wheel();
    test_change_wheel();
    test_frozen_frame();
    test_backpressure();
    test_clock_run();
    s_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("sent %0d ticks, checked %0d frames, %0d of them with wheel digits",
             ticks_sent, beats_seen, wheel_frames);
    $display("covered all four wheel modes, hidden time, noise words and a long output stall");
    if (mismatches == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/nfw_pkg.sv
rtl/nfw_wheel.sv
rtl/nixie_frame_wheel_effect.sv
dv/testbench.sv
